>>> sv/fbpa_pkg.sv
// fbpa_pkg: payload types, operation and status codes, and the command and
// status structs that pass between the pool allocator's controller and datapath.
// Stands alone; every other file of the block imports it.
package fbpa_pkg;

   // operation codes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_FULL         = 2'd1;
   localparam logic [1:0] ST_OUTSIDE      = 2'd2;
   localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_BASE  = 2'd0;
   localparam logic [1:0] CSR_SIZE  = 2'd1;
   localparam logic [1:0] CSR_COUNT = 2'd2;

   // configuration reset values
   localparam logic [31:0] BASE_RESET  = 32'd0;
   localparam logic [15:0] SIZE_RESET  = 16'd16;
   localparam logic [6:0]  COUNT_RESET = 7'd64;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [31:0] block_address;
      logic [1:0]  status;
      logic        is_allocated;
   } rsp_type;

   // which result the datapath builds
   typedef enum logic [2:0] {
      RES_ZERO,
      RES_ALLOC,
      RES_FULL,
      RES_OUTSIDE,
      RES_FREE,
      RES_QUERY
   } res_kind_type;

   // controller to datapath
   typedef struct packed {
      logic         load_req;
      logic         idx_inc;
      logic         rd_next;
      logic         mem_we;
      logic         mem_wbit;
      logic         calc_span;
      logic         div_start;
      logic         div_step;
      logic         load_quot;
      logic         res_load;
      res_kind_type res_kind;
      logic         rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] operation;
      logic       clr_last;
      logic       scan_end;
      logic       next_end;
      logic       bit_used;
      logic       outside;
      logic       div_last;
   } stat_type;

endpackage

>>> sv/fbpa_datapath.sv
// fbpa_datapath: configuration registers, used bitmap memory, scan address
// accumulator, range check, iterative divider and result registers.
// Depends on fbpa_pkg; driven by fbpa_ctrl through cmd_type.
module fbpa_datapath #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data,
   input  fbpa_pkg::req_type req_payload,
   input  fbpa_pkg::cmd_type cmd,
   output fbpa_pkg::stat_type stat,
   output fbpa_pkg::rsp_type rsp_payload
);
   import fbpa_pkg::*;

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = ($clog2(MAX_BLOCKS + 1) > 7) ? $clog2(MAX_BLOCKS + 1) : 7;
   localparam int OFF_W = CNT_W + 16;
   localparam int DC_W  = $clog2(OFF_W);

   logic [31:0]      base_ff;
   logic [15:0]      size_ff;
   logic [6:0]       count_ff;
   logic [15:0]      eff_size;
   logic [CNT_W-1:0] count_ext;
   logic [CNT_W-1:0] eff_count;

   logic [1:0]       op_ff;
   logic [31:0]      addr_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W:0]   idx_p1;
   logic [31:0]      acc_ff;

   logic             used_mem [MAX_BLOCKS];
   logic [IDX_W-1:0] rd_addr;
   logic             rd_bit_ff;

   logic [31:0]      off_ff;
   logic [OFF_W-1:0] span_ff;

   logic [15:0]      rem_ff;
   logic [15:0]      rem_in;
   logic [OFF_W-1:0] quo_ff;
   logic [OFF_W-1:0] quo_in;
   logic [16:0]      rem_sh;
   logic             quo_bit;
   logic [DC_W-1:0]  div_cnt_ff;

   rsp_type          res_ff;
   rsp_type          res_in;
   rsp_type          rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_RESET;
         size_ff  <= SIZE_RESET;
         count_ff <= COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE:  base_ff  <= csr_data;
            CSR_SIZE:  size_ff  <= csr_data[15:0];
            CSR_COUNT: count_ff <= csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   // a zero size counts as one, the count is clamped to the built maximum
   assign eff_size  = (size_ff == 16'd0) ? 16'd1 : size_ff;
   assign count_ext = CNT_W'(count_ff);
   assign eff_count = (count_ext > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : count_ext;

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_payload.operation;
         addr_ff <= req_payload.address;
      end
   end

   // block index: clearing pass, scan position and quotient
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.load_req) begin
         idx_ff <= '0;
      end else if (cmd.load_quot) begin
         idx_ff <= quo_ff[CNT_W-1:0];
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_p1[CNT_W-1:0];
      end
   end

   assign idx_p1 = {1'b0, idx_ff} + (CNT_W + 1)'(1);

   // start address of the block under scan, wraps modulo 2^32
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         acc_ff <= base_ff;
      end else if (cmd.idx_inc) begin
         acc_ff <= acc_ff + {16'd0, eff_size};
      end
   end

   // used bitmap, one write and one registered read per cycle
   assign rd_addr = cmd.rd_next ? idx_p1[IDX_W-1:0] : idx_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         used_mem[idx_ff[IDX_W-1:0]] <= cmd.mem_wbit;
      end
      rd_bit_ff <= used_mem[rd_addr];
   end

   // offset into the pool and pool span
   always_ff @(posedge clock) begin
      if (cmd.calc_span) begin
         off_ff  <= addr_ff - base_ff;
         span_ff <= OFF_W'(eff_count) * OFF_W'(eff_size);
      end
   end

   // restoring divider, one quotient bit per cycle
   assign rem_sh  = {rem_ff, quo_ff[OFF_W-1]};
   assign quo_bit = (rem_sh >= {1'b0, eff_size});
   assign rem_in  = quo_bit ? 16'(rem_sh - {1'b0, eff_size}) : rem_sh[15:0];
   assign quo_in  = {quo_ff[OFF_W-2:0], quo_bit};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= off_ff[OFF_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DC_W'(1);
      end
   end

   // result building
   always_comb begin
      res_in = '0;
      case (cmd.res_kind)
         RES_ALLOC: begin
            res_in.block_address = acc_ff;
            res_in.status        = ST_OK;
         end
         RES_FULL:    res_in.status = ST_FULL;
         RES_OUTSIDE: res_in.status = ST_OUTSIDE;
         RES_FREE:    res_in.status = rd_bit_ff ? ST_OK : ST_ALREADY_FREE;
         RES_QUERY: begin
            res_in.status       = ST_OK;
            res_in.is_allocated = rd_bit_ff;
         end
         default: res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_ff <= res_in;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_payload = rsp_ff;

   // status back to the controller
   assign stat.operation = op_ff;
   assign stat.clr_last  = (idx_ff == CNT_W'(MAX_BLOCKS - 1));
   assign stat.scan_end  = (idx_ff >= eff_count);
   assign stat.next_end  = (idx_p1 >= {1'b0, eff_count});
   assign stat.bit_used  = rd_bit_ff;
   assign stat.outside   = (off_ff >= 32'(span_ff));
   assign stat.div_last  = (div_cnt_ff == DC_W'(OFF_W - 1));

endmodule

>>> sv/fbpa_ctrl.sv
// fbpa_ctrl: sequencer of the pool allocator; clearing pass, allocate scan,
// free and query steps, and the result handshake.
// Depends on fbpa_pkg; drives fbpa_datapath through cmd_type.
module fbpa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_op,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  fbpa_pkg::stat_type stat,
   output fbpa_pkg::cmd_type  cmd
);
   import fbpa_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN_FIRST,
      S_SCAN,
      S_SPAN,
      S_RANGE,
      S_DIVIDE,
      S_LOAD,
      S_LOOK,
      S_CHECK,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.mem_we  = 1'b1;
            cmd.idx_inc = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               unique case (req_op) inside
                  OP_ALLOC:          state_in = S_SCAN_FIRST;
                  OP_FREE, OP_QUERY: state_in = S_SPAN;
                  default: begin
                     cmd.res_load = 1'b1;
                     cmd.res_kind = RES_ZERO;
                     state_in     = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN_FIRST: begin
            if (stat.scan_end) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_FULL;
               state_in     = S_RESP;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // read of the next block overlaps the check of this one
            if (!stat.bit_used) begin
               cmd.mem_we   = 1'b1;
               cmd.mem_wbit = 1'b1;
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_ALLOC;
               state_in     = S_RESP;
            end else if (stat.next_end) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_FULL;
               state_in     = S_RESP;
            end else begin
               cmd.idx_inc = 1'b1;
               cmd.rd_next = 1'b1;
            end
         end
         S_SPAN: begin
            cmd.calc_span = 1'b1;
            state_in      = S_RANGE;
         end
         S_RANGE: begin
            if (stat.outside) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_OUTSIDE;
               state_in     = S_RESP;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load_quot = 1'b1;
            state_in      = S_LOOK;
         end
         S_LOOK: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.res_load = 1'b1;
            if (stat.operation == OP_FREE) begin
               cmd.res_kind = RES_FREE;
               cmd.mem_we   = stat.bit_used;
            end else begin
               cmd.res_kind = RES_QUERY;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output slot: filled on load, emptied by a transfer
   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/fixed_block_pool_allocator.sv
// fixed_block_pool_allocator: top level of the fixed-size block pool allocator.
// Depends on fbpa_pkg, fbpa_ctrl and fbpa_datapath.
//
//   channel   direction   handshake          payload
//   req_      in          valid / stall      fbpa_pkg::req_type
//   rsp_      out         valid / stall      fbpa_pkg::rsp_type
//   csr_      in          valid / ready      csr_index, csr_data
//
// One item at a time. Allocate scans the used bitmap one block a cycle through
// the bitmap memory's read port. Free and query take count width + 16 divider
// steps when the address lies inside the pool, and skip the divider when it
// lies outside the pool. After reset a clearing pass zeroes every entry of the
// bitmap; requests stall meanwhile, configuration writes are taken. A finished
// result waits in the output register while the next request is taken.
module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fbpa_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fbpa_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import fbpa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.operation),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   fbpa_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule
